>>> rtl/caf_pkg.sv
// shared constants, types and tables of the complementary attitude filter
`timescale 1ns / 1ps
package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CORD_W     = 36;  // cordic x and y datapath
  localparam int Z_W        = 27;  // angle accumulator, lsb 2^-16 degree
  localparam int TILT_W     = 18;  // rounded cordic angle, lsb 1/128 degree
  localparam int ANG_W      = 16;  // stored angle
  localparam int WEIGHT_W   = 17;
  localparam int OUT_DATA_W = 64;
  localparam int USER_W     = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  localparam logic signed [Z_W-1:0]    Z_HALF      = 27'sd11796480;
  localparam logic signed [TILT_W-1:0] ANG_HALF    = 18'sd23040;
  localparam logic signed [TILT_W-1:0] ANG_QUARTER = 18'sd11520;
  localparam logic signed [TILT_W-1:0] ANG_FULL    = 18'sd46080;

  // item kind, also the status code of the result
  typedef enum logic [1:0] {
    KIND_FUSE   = 2'd0,
    KIND_SEED   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // atan(2^-i) in degrees, lsb 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:    r = 27'sd2949120;
      5'd1:    r = 27'sd1740967;
      5'd2:    r = 27'sd919879;
      5'd3:    r = 27'sd466945;
      5'd4:    r = 27'sd234379;
      5'd5:    r = 27'sd117304;
      5'd6:    r = 27'sd58666;
      5'd7:    r = 27'sd29335;
      5'd8:    r = 27'sd14668;
      5'd9:    r = 27'sd7334;
      5'd10:   r = 27'sd3667;
      5'd11:   r = 27'sd1833;
      5'd12:   r = 27'sd917;
      5'd13:   r = 27'sd458;
      5'd14:   r = 27'sd229;
      5'd15:   r = 27'sd115;
      5'd16:   r = 27'sd57;
      5'd17:   r = 27'sd29;
      5'd18:   r = 27'sd14;
      5'd19:   r = 27'sd7;
      5'd20:   r = 27'sd4;
      5'd21:   r = 27'sd2;
      5'd22:   r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/complementary_attitude_filter.sv
// top level of the complementary attitude filter
`timescale 1ns / 1ps
// Complementary filter attitude estimator. Each input beat is one IMU sample
// (accel x/y/z at 1/4096 g, gyro pitch and roll rates at 1/16 deg/s, step in
// us); each gives exactly one output beat with the fused pitch and roll, the
// accelerometer-only tilt and a status in tuser (0 fused, 1 seeded, 2 zero
// step rejected). The front tags every sample and drops it into a two-entry
// queue, so the input keeps taking beats while the back works and while a
// result waits on the output register, until the queue is full. The back
// handles one sample at a time: a fused sample passes through the bit-serial
// square root of ay^2+az^2 (roll cordic running beside it), the pitch cordic
// pass and the two parallel blend units (the divide by a constant is a
// multiply by its reciprocal); a seeding sample skips the blend units and a
// rejected one goes straight to the output register. The blend weight
// register can be written at any idle time with cfg_we_i.
module complementary_attitude_filter import caf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // blend weight alpha, unsigned q1.16, values above one act as one
  input  logic                                   cfg_we_i,
  input  logic [WEIGHT_W-1:0]                    cfg_wdata_i,
  // sample beat
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, step_us, zero pad
  input  logic [((5*SAMPLE_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
  // result beat
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pitch_out, roll_out, tilt_pitch, tilt_roll, zero pad
  output logic [OUT_DATA_W-1:0]                  m_axis_tdata,
  // status
  output logic [USER_W-1:0]                      m_axis_tuser
);

  localparam int ItemW = 5 * SAMPLE_WIDTH + 18;

  // front to queue
  logic             push, full;
  logic [ItemW-1:0] push_data;
  // queue to back
  logic             q_valid, q_pop;
  logic [ItemW-1:0] q_data;

  caf_front #(.SampleW(SAMPLE_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  caf_fifo #(.Width(ItemW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // back owns the filter state, the weight register and the output register
  caf_back #(.SampleW(SAMPLE_WIDTH), .Steps(CORDIC_STEPS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> rtl/caf_fifo.sv
// small item queue between the front and the back of the filter
`timescale 1ns / 1ps
module caf_fifo import caf_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/caf_front.sv
// input side: takes sample beats and tags each with its kind
`timescale 1ns / 1ps
module caf_front import caf_pkg::*; #(
  parameter int SampleW = SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((5*SampleW+16+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  push_o,
  output logic [5*SampleW+17:0]                 push_data_o,
  input  logic                                  full_i
);

  localparam int FieldW = 5 * SampleW + 16;

  logic        seeded_q;
  logic [15:0] step_us;
  kind_e       kind;

  assign step_us = s_axis_tdata[FieldW-1 -: 16];

  always_comb begin
    priority if (step_us == '0) begin
      kind = KIND_REJECT;
    end else if (seeded_q) begin
      kind = KIND_FUSE;
    end else begin
      kind = KIND_SEED;
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign push_data_o   = {s_axis_tdata[FieldW-1:0], kind};

  // first sample with a nonzero step seeds the filter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (push_o && (kind == KIND_SEED)) begin
      seeded_q <= 1'b1;
    end
  end

endmodule

>>> rtl/caf_cordic.sv
// vectoring cordic, atan2(y, x) rounded to 1/128 degree
`timescale 1ns / 1ps
module caf_cordic import caf_pkg::*; #(
  parameter int Steps = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [CORD_W-1:0] x_i,
  output logic                     done_o,
  output logic signed [TILT_W-1:0] angle_o
);

  localparam int CntW = $clog2(Steps + 1);

  logic                     busy_q, done_q, zero_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [CORD_W-1:0] x_q, y_q, dx, dy;
  logic signed [Z_W-1:0]    z_q, at, zr;
  logic signed [TILT_W-1:0] angle_q;
  logic                     last;

  assign dx      = y_q >>> cnt_q;
  assign dy      = x_q >>> cnt_q;
  assign at      = atan_step(5'(cnt_q));
  assign last    = (cnt_q == CntW'(Steps));
  assign zr      = z_q + Z_W'(256);
  assign done_o  = done_q;
  assign angle_o = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // left half plane: rotate by 180 degrees first
      if (x_i[CORD_W-1]) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= y_i[CORD_W-1] ? -Z_HALF : Z_HALF;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q && !last) begin
      if (!y_q[CORD_W-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end else if (busy_q) begin
      angle_q <= zero_q ? '0 : zr[Z_W-1:9];
    end
  end

endmodule

>>> rtl/caf_blend.sv
// weighted blend of gyro path and tilt angle with rounding and wrap
`timescale 1ns / 1ps
module caf_blend import caf_pkg::*; #(
  parameter int SampleW = SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [ANG_W-1:0]   old_i,
  input  logic signed [SampleW-1:0] rate_i,
  input  logic [15:0]               dt_i,
  input  logic signed [ANG_W-1:0]   tilt_i,
  input  logic [WEIGHT_W-1:0]       alpha_i,
  output logic                      busy_o,
  output logic signed [ANG_W-1:0]   angle_o
);

  localparam int GW   = (SampleW + 18 > 35) ? SampleW + 18 : 35;
  localparam int AW   = 34;
  localparam int P1W  = GW + 18;
  localparam int P2W  = AW + 18;
  localparam int PW   = GW + 19;
  localparam int QW   = ((SampleW > 16) ? SampleW : 16) + 1;
  localparam int RW   = QW + 1;
  localparam int DIVISOR = 15625;  // 65536 * 125000 / 2^19
  localparam int DW   = QW + 14;   // biased dividend
  localparam int KSH  = DW + 14;   // reciprocal scale, 2^14 above the dividend range
  localparam int MW   = DW + 1;
  localparam int ML   = MW / 2;
  localparam int MH   = MW - ML;
  // rounded-up reciprocal, exact floor quotient for any dividend below 2^DW
  localparam longint unsigned RECIP =
    ((64'd1 << KSH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
  localparam logic [ML-1:0] RECIP_LO = ML'(RECIP);
  localparam logic [MH-1:0] RECIP_HI = MH'(RECIP >> ML);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SUM  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_QUO  = 3'd4;
  localparam logic [2:0] B_WRAP = 3'd5;

  logic [2:0]              st_q;
  logic signed [GW-1:0]    g_q;
  logic signed [AW-1:0]    a_q;
  logic [WEIGHT_W-1:0]     alpha_q;
  logic signed [P1W-1:0]   p1_q;
  logic signed [P2W-1:0]   p2_q;
  logic signed [PW-1:0]    t, vb;
  logic [DW-1:0]           divd, u_q;
  logic [DW+ML-1:0]        plo_q;
  logic [DW+MH-1:0]        phi_q;
  logic [DW+MW-1:0]        prod;
  logic [QW-1:0]           q_fin;
  logic signed [RW-1:0]    res_q;

  assign t     = PW'(p1_q) + PW'(p2_q) + PW'(64'sd4096000000);
  // floor(t / 2^19) plus a bias that keeps the dividend positive
  assign vb    = PW'(t[PW-1:19]) + (PW'(DIVISOR) <<< (QW - 1));
  assign divd  = vb[DW-1:0];
  // divide by the constant as a multiply by its reciprocal, two partial products
  assign prod  = {phi_q, {ML{1'b0}}} + (DW+MW)'(plo_q);
  assign q_fin = prod[KSH +: QW];

  assign busy_o  = (st_q != B_IDLE);
  assign angle_o = res_q[ANG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      unique case (st_q)
        B_IDLE: if (start_i) begin
          st_q <= B_MUL;
        end
        B_MUL: st_q <= B_SUM;
        B_SUM: st_q <= B_DIV;
        B_DIV: st_q <= B_QUO;
        B_QUO: st_q <= B_WRAP;
        B_WRAP: begin
          if ((res_q <= RW'(ANG_HALF)) && (res_q >= -RW'(ANG_HALF))) begin
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: if (start_i) begin
        g_q     <= GW'(old_i) * GW'(18'sd125000) + GW'(rate_i) * GW'($signed({1'b0, dt_i}));
        a_q     <= AW'(tilt_i) * AW'(18'sd125000);
        alpha_q <= alpha_i;
      end
      B_MUL: begin
        p1_q <= P1W'(g_q) * P1W'($signed({1'b0, alpha_q}));
        p2_q <= P2W'(a_q) * P2W'($signed({1'b0, WEIGHT_ONE - alpha_q}));
      end
      B_SUM: begin
        u_q <= divd;
      end
      B_DIV: begin
        plo_q <= (DW+ML)'(u_q) * (DW+ML)'(RECIP_LO);
        phi_q <= (DW+MH)'(u_q) * (DW+MH)'(RECIP_HI);
      end
      B_QUO: begin
        // remove the bias: flip the quotient msb
        res_q <= RW'($signed({~q_fin[QW-1], q_fin[QW-2:0]}));
      end
      B_WRAP: begin
        if (res_q > RW'(ANG_HALF)) begin
          res_q <= res_q - RW'(ANG_FULL);
        end else if (res_q < -RW'(ANG_HALF)) begin
          res_q <= res_q + RW'(ANG_FULL);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/caf_back.sv
// execution side: square root, cordic tilt, blend and the result register
`timescale 1ns / 1ps
module caf_back import caf_pkg::*; #(
  parameter int SampleW = SAMPLE_WIDTH_DEF,
  parameter int Steps   = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WEIGHT_W-1:0]     cfg_wdata_i,
  input  logic                    q_valid_i,
  input  logic [5*SampleW+17:0]   q_data_i,
  output logic                    q_pop_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [USER_W-1:0]       m_axis_tuser
);

  localparam int S = 32 - SampleW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQRT  = 3'd1;
  localparam logic [2:0] ST_PGO   = 3'd2;
  localparam logic [2:0] ST_PITCH = 3'd3;
  localparam logic [2:0] ST_BGO   = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                st_q;
  logic [4:0]                cnt_q;
  logic [WEIGHT_W-1:0]       weight_q, alpha;
  logic signed [ANG_W-1:0]   pitch_q, roll_q, tp_q, tr_q, new_pitch, new_roll;
  logic                      m_valid_q, ld;
  logic [OUT_DATA_W-1:0]     m_data_q;
  logic [USER_W-1:0]         m_user_q;

  kind_e                     kind_in, kind_q;
  logic signed [SampleW-1:0] ax_in, ay_in, az_in, rx_in, ry_in;
  logic signed [SampleW-1:0] ax_q, rx_q, ry_q;
  logic [15:0]               dt_in, dt_q;
  logic signed [2*SampleW-1:0] ay_sq, az_sq;
  logic [2*SampleW-1:0]      sq_sum;

  logic [63:0]               n_q;
  logic [33:0]               rem_q;
  logic [31:0]               root_q;
  logic [35:0]               rem_n;
  logic [33:0]               trial;
  logic                      ge;

  logic                      cord_start, cord_done;
  logic signed [CORD_W-1:0]  cord_y, cord_x;
  logic signed [TILT_W-1:0]  cord_angle, tp_c, tr_c;
  logic                      bstart, bp_busy, br_busy;
  logic signed [ANG_W-1:0]   bp_angle, br_angle;

  // item unpacking
  assign kind_in = kind_e'(q_data_i[1:0]);
  assign ax_in   = $signed(q_data_i[2 +: SampleW]);
  assign ay_in   = $signed(q_data_i[2 + SampleW +: SampleW]);
  assign az_in   = $signed(q_data_i[2 + 2*SampleW +: SampleW]);
  assign rx_in   = $signed(q_data_i[2 + 3*SampleW +: SampleW]);
  assign ry_in   = $signed(q_data_i[2 + 4*SampleW +: SampleW]);
  assign dt_in   = q_data_i[2 + 5*SampleW +: 16];

  assign ay_sq  = (2*SampleW)'(ay_in) * (2*SampleW)'(ay_in);
  assign az_sq  = (2*SampleW)'(az_in) * (2*SampleW)'(az_in);
  assign sq_sum = ay_sq + az_sq;

  assign alpha = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;

  // integer square root, one root bit per cycle
  assign rem_n = {rem_q, n_q[63:62]};
  assign trial = {root_q, 2'b01};
  assign ge    = (rem_n >= 36'(trial));

  // shared cordic: roll during the square root, pitch after it
  assign cord_start = (q_pop_o && (kind_in != KIND_REJECT)) || (st_q == ST_PGO);
  assign cord_y = (st_q == ST_IDLE) ? (CORD_W'(ay_in) <<< S) : -(CORD_W'(ax_q) <<< S);
  assign cord_x = (st_q == ST_IDLE) ? (CORD_W'(az_in) <<< S)
                                    : $signed({{(CORD_W-32){1'b0}}, root_q});

  caf_cordic #(.Steps(Steps)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (cord_x),
    .done_o  (cord_done),
    .angle_o (cord_angle)
  );

  always_comb begin
    tp_c = cord_angle;
    if (cord_angle > ANG_QUARTER) begin
      tp_c = ANG_QUARTER;
    end else if (cord_angle < -ANG_QUARTER) begin
      tp_c = -ANG_QUARTER;
    end
    tr_c = cord_angle;
    if (cord_angle > ANG_HALF) begin
      tr_c = cord_angle - ANG_FULL;
    end else if (cord_angle < -ANG_HALF) begin
      tr_c = cord_angle + ANG_FULL;
    end
  end

  assign bstart = (st_q == ST_BGO);

  caf_blend #(.SampleW(SampleW)) u_blend_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bstart),
    .old_i   (pitch_q),
    .rate_i  (rx_q),
    .dt_i    (dt_q),
    .tilt_i  (tp_q),
    .alpha_i (alpha),
    .busy_o  (bp_busy),
    .angle_o (bp_angle)
  );

  caf_blend #(.SampleW(SampleW)) u_blend_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bstart),
    .old_i   (roll_q),
    .rate_i  (ry_q),
    .dt_i    (dt_q),
    .tilt_i  (tr_q),
    .alpha_i (alpha),
    .busy_o  (br_busy),
    .angle_o (br_angle)
  );

  always_comb begin
    unique case (kind_q)
      KIND_FUSE: begin
        new_pitch = bp_angle;
        new_roll  = br_angle;
      end
      KIND_SEED: begin
        new_pitch = tp_q;
        new_roll  = tr_q;
      end
      default: begin
        new_pitch = pitch_q;
        new_roll  = roll_q;
      end
    endcase
  end

  assign ld = (st_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      weight_q  <= WEIGHT_RESET;
      pitch_q   <= '0;
      roll_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (ld) begin
        m_valid_q <= 1'b1;
        pitch_q   <= new_pitch;
        roll_q    <= new_roll;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: if (q_valid_i) begin
          cnt_q <= '0;
          st_q  <= (kind_in == KIND_REJECT) ? ST_OUT : ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            st_q <= ST_PGO;
          end
        end
        ST_PGO:   st_q <= ST_PITCH;
        ST_PITCH: if (cord_done) begin
          st_q <= (kind_q == KIND_FUSE) ? ST_BGO : ST_OUT;
        end
        ST_BGO:   st_q <= ST_BLEND;
        ST_BLEND: if (!bp_busy && !br_busy) begin
          st_q <= ST_OUT;
        end
        ST_OUT:   if (ld) begin
          st_q <= ST_IDLE;
        end
        default:  st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q <= kind_in;
      ax_q   <= ax_in;
      rx_q   <= rx_in;
      ry_q   <= ry_in;
      dt_q   <= dt_in;
      n_q    <= {sq_sum, {(64-2*SampleW){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
      tp_q   <= '0;
      tr_q   <= '0;
    end else if (st_q == ST_SQRT) begin
      n_q    <= {n_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_n - 36'(trial)) : rem_n[33:0];
      root_q <= {root_q[30:0], ge};
    end else if (st_q == ST_PGO) begin
      tr_q <= tr_c[ANG_W-1:0];
    end else if ((st_q == ST_PITCH) && cord_done) begin
      tp_q <= tp_c[ANG_W-1:0];
    end
    if (ld) begin
      m_data_q <= {1'b0, tr_q, tp_q[14:0], new_roll, new_pitch};
      m_user_q <= kind_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_reject_zero_tilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_user_q == KIND_REJECT)) |-> (m_data_q[62:32] == '0))
    else $error("rejected beat carries a tilt");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (($signed(m_data_q[15:0]) <= 16'sd23040)
               && ($signed(m_data_q[15:0]) >= -16'sd23040)
               && ($signed(m_data_q[31:16]) <= 16'sd23040)
               && ($signed(m_data_q[31:16]) >= -16'sd23040)))
    else $error("fused angle outside half turn");

  a_state_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> ((pitch_q == $signed(m_data_q[15:0])) && (roll_q == $signed(m_data_q[31:16]))))
    else $error("stored angles differ from the shown beat");

  a_pitch_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (($signed(m_data_q[46:32]) <= 15'sd11520)
               && ($signed(m_data_q[46:32]) >= -15'sd11520)))
    else $error("tilt pitch beyond quarter turn");
`endif

endmodule

>>> tb/complementary_attitude_filter_tb.sv
// testbench of the complementary attitude filter: directed and random imu samples
`timescale 1ns / 1ps
module complementary_attitude_filter_tb;
  import caf_pkg::*;

  localparam int SW         = 16;
  localparam int IN_W       = ((5*SW+16+7)/8)*8;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 150;

  typedef struct {
    logic signed [15:0] ax, ay, az, rx, ry;
    logic        [15:0] dt;
  } imu_sample_t;

  typedef struct {
    logic signed [15:0] pitch, roll;
    logic signed [14:0] tilt_p;
    logic signed [15:0] tilt_r;
    kind_e              status;
  } attitude_t;

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [WEIGHT_W-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid, s_axis_tready;
  // accel_x, accel_y, accel_z, rate_x, rate_y, step_us
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid, m_axis_tready;
  // pitch_out, roll_out, tilt_pitch, tilt_roll, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status
  logic [USER_W-1:0]    m_axis_tuser;

  complementary_attitude_filter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    clk_i = 1'b0; #4;
    clk_i = 1'b1; #4;
  end

  // predictor state
  longint              pitch_st, roll_st;
  bit                  seeded_st;
  logic [WEIGHT_W-1:0] weight_st;
  attitude_t           pending_q[$];

  int unsigned idle_pct, stall_pct;
  int unsigned mismatches;
  int unsigned cycles;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, result in 1/128 degree
  function automatic longint arctan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: rotate by 180 first
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_step(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_step(i[4:0]));
      end
    end
    return (z + 256) >>> 9;
  endfunction

  function automatic longint wrap_deg(longint v);
    if (v > 23040) v -= ((v - 23040 + 46080 - 1) / 46080) * 46080;
    if (v < -23040) v += ((-23040 - v + 46080 - 1) / 46080) * 46080;
    return v;
  endfunction

  function automatic longint fuse_angle(longint prev, longint rate, longint dt,
                                        longint tilt, longint alpha);
    longint g, a, num, d, t, q;
    g   = prev * 125000 + rate * dt;
    a   = tilt * 125000;
    num = alpha * g + (65536 - alpha) * a;
    d   = 64'sd65536 * 125000;
    t   = num + d / 2;
    if (t >= 0) q = t / d;
    else q = -((-t + d - 1) / d);
    return wrap_deg(q);
  endfunction

  function automatic attitude_t predict_attitude(imu_sample_t s);
    attitude_t       e;
    longint          tp, tr, mag, alpha;
    longint unsigned sq;
    tp = 0;
    tr = 0;
    if (s.dt == 0) begin
      e.status = KIND_REJECT;
    end else begin
      sq    = longint'(s.ay) * s.ay + longint'(s.az) * s.az;
      mag   = longint'(int_sqrt(sq << 32));
      alpha = (weight_st > WEIGHT_ONE) ? 65536 : longint'(weight_st);
      tp    = arctan2(-longint'(s.ax) * 65536, mag);
      if (tp > 11520) tp = 11520;
      if (tp < -11520) tp = -11520;
      tr = wrap_deg(arctan2(longint'(s.ay) * 65536, longint'(s.az) * 65536));
      if (!seeded_st) begin
        pitch_st  = tp;
        roll_st   = tr;
        seeded_st = 1'b1;
        e.status  = KIND_SEED;
      end else begin
        pitch_st = fuse_angle(pitch_st, s.rx, s.dt, tp, alpha);
        roll_st  = fuse_angle(roll_st, s.ry, s.dt, tr, alpha);
        e.status = KIND_FUSE;
      end
    end
    e.pitch  = pitch_st[15:0];
    e.roll   = roll_st[15:0];
    e.tilt_p = tp[14:0];
    e.tilt_r = tr[15:0];
    return e;
  endfunction

  // one sample beat; returns at the falling edge after acceptance, tvalid still high
  task automatic send_sample(imu_sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.dt, s.ry, s.rx, s.az, s.ay, s.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict_attitude(s));
    @(negedge clk_i);
  endtask

  task automatic send(int ax, int ay, int az, int rx, int ry, int dt);
    imu_sample_t s;
    s.ax = ax[15:0]; s.ay = ay[15:0]; s.az = az[15:0];
    s.rx = rx[15:0]; s.ry = ry[15:0]; s.dt = dt[15:0];
    send_sample(s);
  endtask

  // only while idle: drain first, then write
  task automatic write_weight(logic [WEIGHT_W-1:0] w);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    weight_st = w;
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // zero step before seeding gives the reset angles
    send(4096, 0, 4096, 100, -100, 0);
    // zero vector seeds with zero angles
    send(0, 0, 0, 0, 0, 1000);
    send(0, 0, 0, 32767, -32768, 65535);
    // negative z with zero y: roll at +180
    send(0, 0, -4096, 0, 0, 1000);
    send(-32768, -32768, -32768, -32768, -32768, 65535);
    send(32767, 32767, 32767, 32767, 32767, 1);
    send(32767, 0, 0, 0, 0, 500);       // pitch near -90
    send(-32768, 0, 0, 0, 0, 500);      // pitch near +90
    send(0, -1, -4096, 200, 200, 0);    // rejected after seeding
    send(0, 1, -32768, -5, 5, 10000);
    write_weight(17'd0);
    send(1000, -2000, 3000, 32767, -32768, 65535);
    write_weight(WEIGHT_ONE);
    send(1000, -2000, 3000, 32767, 32767, 65535);
    send(0, 0, 4096, 32767, 32767, 65535);
    write_weight(17'h1FFFF);             // above one acts as one
    send(0, 0, 4096, -32768, -32768, 65535);
    send(-1, -1, -1, 1, 1, 2);
  endtask

  function automatic int near(int base, int spread);
    return base + $urandom_range(2*spread) - spread;
  endfunction

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall,
                             logic [WEIGHT_W-1:0] w);
    imu_sample_t s;
    write_weight(w);
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        // plausible motion: az near +-4096, ax near 0 or -4096, moderate rates
        s.ax = 16'(near($urandom_range(1) ? 0 : -4096, 4096));
        s.ay = 16'(near(0, 4096));
        s.az = 16'(near($urandom_range(1) ? 4096 : -4096, 3000));
        s.rx = 16'(near(0, 4000));
        s.ry = 16'(near(0, 4000));
        s.dt = 16'($urandom_range(20000, 1));
      end else begin
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        s.rx = 16'($urandom); s.ry = 16'($urandom); s.dt = 16'($urandom);
      end
      if ($urandom_range(19) == 0) s.dt = '0;
      send_sample(s);
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result check
  always @(posedge clk_i) begin
    attitude_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        mismatches++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[15:0] !== e.pitch) begin
          $error("pitch_out exp %0d got %0d", e.pitch, $signed(m_axis_tdata[15:0]));
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== e.roll) begin
          $error("roll_out exp %0d got %0d", e.roll, $signed(m_axis_tdata[31:16]));
          mismatches++;
        end
        if (m_axis_tdata[46:32] !== e.tilt_p) begin
          $error("tilt_pitch exp %0d got %0d", e.tilt_p, $signed(m_axis_tdata[46:32]));
          mismatches++;
        end
        if (m_axis_tdata[62:47] !== e.tilt_r) begin
          $error("tilt_roll exp %0d got %0d", e.tilt_r, $signed(m_axis_tdata[62:47]));
          mismatches++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("complementary_attitude_filter test failed");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    mismatches    = 0;
    cycles        = 0;
    pitch_st      = 0;
    roll_st       = 0;
    seeded_st     = 1'b0;
    weight_st     = WEIGHT_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(225, 0, 0, WEIGHT_RESET);
    test_random(225, 48, 0, 17'd32768);
    test_random(225, 0, 48, WEIGHT_ONE);
    test_random(225, 22, 22, 17'($urandom));

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("complementary_attitude_filter test passed");
    end else begin
      $display("complementary_attitude_filter test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/caf_pkg.sv
rtl/caf_fifo.sv
rtl/caf_front.sv
rtl/caf_cordic.sv
rtl/caf_blend.sv
rtl/caf_back.sv
rtl/complementary_attitude_filter.sv
tb/complementary_attitude_filter_tb.sv
